/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and constants for the bus sequencer, the register file and
// the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [6:0]  DevAddrReset    = 7'd100;
   localparam logic [15:0] PhaseTicksReset = 16'd18;
   localparam logic [7:0]  RetryLimitReset = 8'd100;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS  = 2'd0,
      CSR_PHASE_TICKS     = 2'd1,
      CSR_ACK_RETRY_LIMIT = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_SUPPLY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STG_ADDR_W  = 2'd0,
      STG_POINTER = 2'd1,
      STG_ADDR_R  = 2'd2,
      STG_DATA    = 2'd3
   } stage_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_SA   = 5'd1,
      PH_SB   = 5'd2,
      PH_WA   = 5'd3,
      PH_WB   = 5'd4,
      PH_WC   = 5'd5,
      PH_AA   = 5'd6,
      PH_AB   = 5'd7,
      PH_AC   = 5'd8,
      PH_WAIT = 5'd9,
      PH_RA   = 5'd10,
      PH_RB   = 5'd11,
      PH_MA   = 5'd12,
      PH_MB   = 5'd13,
      PH_MC   = 5'd14,
      PH_NA   = 5'd15,
      PH_NB   = 5'd16,
      PH_NC   = 5'd17,
      PH_PA   = 5'd18,
      PH_PB   = 5'd19,
      PH_PC   = 5'd20,
      PH_PD   = 5'd21
   } phase_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] phase_ticks;
      logic [7:0]  ack_retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       rd_last;
      logic       need_data;
      logic       done_res;
      logic       nack_error;
      logic       busy_res;
   } rsp_type;

endpackage

/* rtl/i2cm_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master configuration registers
// APB-style register file holding device address, phase length and the
// acknowledge retry limit.
// ----------------------------------------------------------------------------
module i2cm_csr import i2cm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_DEVICE_ADDRESS:  cfg_in.device_address  = csr_pwdata[6:0];
            CSR_PHASE_TICKS:     cfg_in.phase_ticks     = csr_pwdata[15:0];
            CSR_ACK_RETRY_LIMIT: cfg_in.ack_retry_limit = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         CSR_DEVICE_ADDRESS:  csr_prdata[6:0]  = cfg_ff.device_address;
         CSR_PHASE_TICKS:     csr_prdata[15:0] = cfg_ff.phase_ticks;
         CSR_ACK_RETRY_LIMIT: csr_prdata[7:0]  = cfg_ff.ack_retry_limit;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address  <= DevAddrReset;
         cfg_ff.phase_ticks     <= PhaseTicksReset;
         cfg_ff.ack_retry_limit <= RetryLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/i2cm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Phase state machine that advances by one bus tick per accepted beat and
// forms the line drives and status of that tick.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   phase_type   phase_ff, phase_in;
   stage_type   stage_ff, stage_in;
   logic [15:0] count_ff, count_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  retry_ff, retry_in;
   logic        read_ff, read_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic        ack_ff, ack_in;
   logic        abort_ff, abort_in;

   logic [15:0] ticks;
   logic [7:0]  limit;
   logic        phase_end;
   logic        retry_out;
   logic        tx_bit;
   cmd_type     cmd;

   assign ticks     = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
   assign limit     = (cfg.ack_retry_limit == 8'd0) ? 8'd1 : cfg.ack_retry_limit;
   assign phase_end = ({1'b0, count_ff} + 17'd1) >= {1'b0, ticks};
   assign retry_out = ({1'b0, retry_ff} + 9'd1) >= {1'b0, limit};
   assign tx_bit    = shift_ff[7];
   assign cmd       = cmd_type'(req.cmd);

   always_comb begin
      phase_in = phase_ff;
      stage_in = stage_ff;
      count_in = count_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      retry_in = retry_ff;
      read_in  = read_ff;
      ptr_in   = ptr_ff;
      ack_in   = ack_ff;
      abort_in = abort_ff;
      rsp      = '0;

      rsp.scl_out = 1'b1;
      rsp.sda_out = 1'b1;
      unique case (phase_ff)
         PH_SB, PH_MB, PH_PB: rsp.sda_out = 1'b0;
         PH_WA: begin
            rsp.scl_out = 1'b0;
            rsp.sda_out = tx_bit;
         end
         PH_WB: rsp.sda_out = tx_bit;
         PH_WC: begin
            rsp.scl_out = 1'b0;
            rsp.sda_out = (bit_ff == 3'd7) ? 1'b1 : tx_bit;
         end
         PH_AC, PH_WAIT, PH_RB, PH_MC, PH_NA, PH_NC: rsp.scl_out = 1'b0;
         PH_MA, PH_PA: begin
            rsp.scl_out = 1'b0;
            rsp.sda_out = 1'b0;
         end
         default: ;
      endcase
      rsp.need_data = (phase_ff == PH_WAIT);
      rsp.busy_res  = (phase_ff != PH_IDLE);

      if (phase_ff == PH_IDLE) begin
         if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            read_in  = (cmd == CMD_READ);
            ptr_in   = req.reg_addr;
            left_in  = req.byte_count;
            retry_in = '0;
            abort_in = 1'b0;
            ack_in   = 1'b0;
            stage_in = STG_ADDR_W;
            bit_in   = '0;
            shift_in = {cfg.device_address, 1'b0};
            phase_in = PH_SA;
            count_in = '0;
         end
      end else if (phase_ff == PH_WAIT) begin
         if (cmd == CMD_SUPPLY) begin
            shift_in = req.write_data;
            bit_in   = '0;
            phase_in = PH_WA;
            count_in = '0;
         end
      end else if (!phase_end) begin
         count_in = count_ff + 16'd1;
      end else begin
         count_in = '0;
         unique case (phase_ff)
            PH_SA: phase_in = PH_SB;
            PH_SB: begin
               bit_in   = '0;
               phase_in = PH_WA;
            end
            PH_WA: phase_in = PH_WB;
            PH_WB: phase_in = PH_WC;
            PH_WC: begin
               if (bit_ff == 3'd7) begin
                  bit_in   = '0;
                  ack_in   = 1'b0;
                  phase_in = PH_AA;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  shift_in = {shift_ff[6:0], 1'b0};
                  phase_in = PH_WA;
               end
            end
            PH_AA: begin
               ack_in   = ~req.sda_in;
               phase_in = PH_AB;
            end
            PH_AB: phase_in = PH_AC;
            PH_AC: begin
               if (ack_ff) begin
                  retry_in = '0;
                  unique case (stage_ff)
                     STG_ADDR_W: begin
                        stage_in = STG_POINTER;
                        shift_in = ptr_ff;
                        bit_in   = '0;
                        phase_in = PH_WA;
                     end
                     STG_POINTER: begin
                        if (read_ff) begin
                           stage_in = STG_ADDR_R;
                           shift_in = {cfg.device_address, 1'b1};
                           phase_in = PH_SA;
                        end else if (left_ff == 8'd0) begin
                           phase_in = PH_PA;
                        end else begin
                           stage_in = STG_DATA;
                           phase_in = PH_WAIT;
                        end
                     end
                     STG_ADDR_R: begin
                        if (left_ff == 8'd0) begin
                           phase_in = PH_NA;
                        end else begin
                           shift_in = '0;
                           bit_in   = '0;
                           phase_in = PH_RA;
                        end
                     end
                     STG_DATA: begin
                        left_in  = left_ff - 8'd1;
                        phase_in = (left_ff == 8'd1) ? PH_PA : PH_WAIT;
                     end
                     default: ;
                  endcase
               end else if (retry_out) begin
                  abort_in = 1'b1;
                  phase_in = PH_PA;
               end else begin
                  retry_in = retry_ff + 8'd1;
                  phase_in = PH_AA;
               end
            end
            PH_RA: begin
               shift_in = {shift_ff[6:0], req.sda_in};
               phase_in = PH_RB;
            end
            PH_RB: begin
               if (bit_ff == 3'd7) begin
                  bit_in       = '0;
                  rsp.rd_data  = shift_ff;
                  rsp.rd_valid = 1'b1;
                  rsp.rd_last  = (left_ff == 8'd1);
                  left_in      = left_ff - 8'd1;
                  phase_in     = (left_ff == 8'd1) ? PH_NA : PH_MA;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_RA;
               end
            end
            PH_MA: phase_in = PH_MB;
            PH_MB: phase_in = PH_MC;
            PH_MC: begin
               shift_in = '0;
               bit_in   = '0;
               phase_in = PH_RA;
            end
            PH_NA: phase_in = PH_NB;
            PH_NB: phase_in = PH_NC;
            PH_NC: phase_in = PH_PA;
            PH_PA: phase_in = PH_PB;
            PH_PB: phase_in = PH_PC;
            PH_PC: phase_in = PH_PD;
            PH_PD: begin
               rsp.done_res   = 1'b1;
               rsp.nack_error = abort_ff;
               abort_in       = 1'b0;
               retry_in       = '0;
               bit_in         = '0;
               phase_in       = PH_IDLE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stage_ff <= STG_ADDR_W;
         count_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         left_ff  <= '0;
         retry_ff <= '0;
         read_ff  <= 1'b0;
         ptr_ff   <= '0;
         ack_ff   <= 1'b0;
         abort_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         stage_ff <= stage_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         retry_ff <= retry_in;
         read_ff  <= read_in;
         ptr_ff   <= ptr_in;
         ack_ff   <= ack_in;
         abort_ff <= abort_in;
      end
   end

   a_wait_in_data_stage: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> stage_ff == STG_POINTER || stage_ff == STG_DATA)
      else $error("wait phase outside a write transfer");

   a_count_below_ticks: assert property (@(posedge clock) disable iff (reset)
      $past(step) && !$past(reset) |-> count_ff < ticks || $past(count_ff) >= ticks
      || $changed(cfg.phase_ticks))
      else $error("phase counter ran past the phase length");

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> count_ff == 16'd0 && bit_ff == 3'd0 && !abort_ff)
      else $error("sequencer idle with stale counters");

endmodule

/* rtl/i2c_master_register_access.sv */
`timescale 1ns / 1ps
// A result beat appears in the output register in the cycle after its request beat.
// One request beat per cycle unless the output register stalls; one bus tick per beat.
// A stalled output register holds one result while the sequencer waits behind it.
// Reset is synchronous and active high; it returns the bus sequencer to idle and
// restores device address 100, 18 ticks per phase and 100 ack retries.
// ----------------------------------------------------------------------------
// I2C master register access
// Bit-level I2C master for register reads and writes with an APB-style
// configuration port and a registered result channel.
// ----------------------------------------------------------------------------
module i2c_master_register_access import i2cm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic [7:0]              req_reg_addr,
   input  logic [7:0]              req_byte_count,
   input  logic [7:0]              req_write_data,
   input  logic                    req_sda_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_scl_out,
   output logic                    rsp_sda_out,
   output logic [7:0]              rsp_rd_data,
   output logic                    rsp_rd_valid,
   output logic                    rsp_rd_last,
   output logic                    rsp_need_data,
   output logic                    rsp_done_res,
   output logic                    rsp_nack_error,
   output logic                    rsp_busy_res,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;
   req_type req;
   rsp_type rsp_next;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    step;

   assign req.cmd        = req_cmd;
   assign req.reg_addr   = req_reg_addr;
   assign req.byte_count = req_byte_count;
   assign req.write_data = req_write_data;
   assign req.sda_in     = req_sda_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   i2cm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp_next)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (step) begin
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_out    = rsp_ff.scl_out;
   assign rsp_sda_out    = rsp_ff.sda_out;
   assign rsp_rd_data    = rsp_ff.rd_data;
   assign rsp_rd_valid   = rsp_ff.rd_valid;
   assign rsp_rd_last    = rsp_ff.rd_last;
   assign rsp_need_data  = rsp_ff.need_data;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_nack_error = rsp_ff.nack_error;
   assign rsp_busy_res   = rsp_ff.busy_res;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with an empty output register");

   a_error_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.nack_error |-> rsp_ff.done_res && rsp_ff.busy_res)
      else $error("error flagged without the final stop");

   a_last_with_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rd_last |-> rsp_ff.rd_valid && !rsp_ff.done_res)
      else $error("last flag without a received byte");

endmodule

/* sim/i2c_master_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bus tick checker
// Watches the request, result and configuration ports of the I2C master. It
// keeps its own copy of the bus sequencer and the registers, works out the
// line levels and status of every accepted request beat, and compares each
// result beat with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module i2c_master_checker import i2cm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic [7:0]              req_reg_addr,
   input  logic [7:0]              req_byte_count,
   input  logic [7:0]              req_write_data,
   input  logic                    req_sda_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_scl_out,
   input  logic                    rsp_sda_out,
   input  logic [7:0]              rsp_rd_data,
   input  logic                    rsp_rd_valid,
   input  logic                    rsp_rd_last,
   input  logic                    rsp_need_data,
   input  logic                    rsp_done_res,
   input  logic                    rsp_nack_error,
   input  logic                    rsp_busy_res,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   input  logic                    csr_pready,
   output int unsigned             mismatches,
   output int unsigned             outstanding
);

   logic [6:0]  dev_addr;
   logic [15:0] ticks_cfg;
   logic [7:0]  retry_cfg;

   phase_type   ph;
   stage_type   stg;
   logic [15:0] phase_cnt;
   logic [3:0]  bit_cnt;
   logic [7:0]  shifter;
   logic [7:0]  bytes_left;
   logic [7:0]  retries;
   logic [7:0]  pointer;
   logic        reading;
   logic        ack_low;
   logic        aborting;

   rsp_type     bus_tick_results[$];
   int unsigned mismatch_total = 0;
   int unsigned beat_no = 0;

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   function automatic void clear_bus_model();
      dev_addr = DevAddrReset;
      ticks_cfg = PhaseTicksReset;
      retry_cfg = RetryLimitReset;
      ph = PH_IDLE;
      stg = STG_ADDR_W;
      phase_cnt = '0;
      bit_cnt = '0;
      shifter = '0;
      bytes_left = '0;
      retries = '0;
      pointer = '0;
      reading = 1'b0;
      ack_low = 1'b0;
      aborting = 1'b0;
   endfunction

   function automatic void enter(phase_type p);
      ph = p;
      phase_cnt = '0;
   endfunction

   function automatic void load_byte(logic [7:0] b);
      shifter = b;
      bit_cnt = '0;
      enter(PH_WA);
   endfunction

   function automatic void ack_taken();
      retries = '0;
      case (stg)
         STG_ADDR_W: begin
            stg = STG_POINTER;
            load_byte(pointer);
         end
         STG_POINTER: begin
            if (reading) begin
               stg = STG_ADDR_R;
               shifter = {dev_addr, 1'b1};
               enter(PH_SA);
            end else if (bytes_left == 0) begin
               enter(PH_PA);
            end else begin
               stg = STG_DATA;
               enter(PH_WAIT);
            end
         end
         STG_ADDR_R: begin
            if (bytes_left == 0) begin
               enter(PH_NA);
            end else begin
               shifter = '0;
               bit_cnt = '0;
               enter(PH_RA);
            end
         end
         default: begin
            bytes_left = bytes_left - 8'd1;
            enter(bytes_left == 0 ? PH_PA : PH_WAIT);
         end
      endcase
   endfunction

   // Advances the sequencer by one bus tick and returns what the block shows for it.
   function automatic rsp_type next_bus_tick(cmd_type op, logic [7:0] reg_addr,
                                             logic [7:0] count, logic [7:0] data,
                                             logic sda);
      rsp_type     r;
      int unsigned span;
      int unsigned lim;
      logic        msb;
      span = (ticks_cfg == 0) ? 1 : ticks_cfg;
      lim = (retry_cfg == 0) ? 1 : retry_cfg;
      msb = shifter[7];
      r = '0;
      r.scl_out = 1'b1;
      r.sda_out = 1'b1;
      case (ph)
         PH_SB, PH_MB, PH_PB: r.sda_out = 1'b0;
         PH_WA: begin
            r.scl_out = 1'b0;
            r.sda_out = msb;
         end
         PH_WB: r.sda_out = msb;
         PH_WC: begin
            r.scl_out = 1'b0;
            r.sda_out = (bit_cnt >= 7) ? 1'b1 : msb;
         end
         PH_AC, PH_WAIT, PH_RB, PH_MC, PH_NA, PH_NC: r.scl_out = 1'b0;
         PH_MA, PH_PA: begin
            r.scl_out = 1'b0;
            r.sda_out = 1'b0;
         end
         default: ;
      endcase
      r.need_data = (ph == PH_WAIT);
      r.busy_res = (ph != PH_IDLE);

      if (ph == PH_IDLE) begin
         if (op == CMD_WRITE || op == CMD_READ) begin
            reading = (op == CMD_READ);
            pointer = reg_addr;
            bytes_left = count;
            retries = '0;
            aborting = 1'b0;
            ack_low = 1'b0;
            stg = STG_ADDR_W;
            bit_cnt = '0;
            shifter = {dev_addr, 1'b0};
            enter(PH_SA);
         end
      end else if (ph == PH_WAIT) begin
         if (op == CMD_SUPPLY) load_byte(data);
      end else if (int'(phase_cnt) + 1 < span) begin
         phase_cnt = phase_cnt + 16'd1;
      end else begin
         phase_cnt = '0;
         case (ph)
            PH_SA: enter(PH_SB);
            PH_SB: begin
               bit_cnt = '0;
               enter(PH_WA);
            end
            PH_WA: enter(PH_WB);
            PH_WB: enter(PH_WC);
            PH_WC: begin
               if (bit_cnt >= 7) begin
                  bit_cnt = '0;
                  ack_low = 1'b0;
                  enter(PH_AA);
               end else begin
                  bit_cnt = bit_cnt + 4'd1;
                  shifter = {shifter[6:0], 1'b0};
                  enter(PH_WA);
               end
            end
            PH_AA: begin
               ack_low = !sda;
               enter(PH_AB);
            end
            PH_AB: enter(PH_AC);
            PH_AC: begin
               if (ack_low) begin
                  ack_taken();
               end else if (int'(retries) + 1 >= lim) begin
                  aborting = 1'b1;
                  enter(PH_PA);
               end else begin
                  retries = retries + 8'd1;
                  enter(PH_AA);
               end
            end
            PH_RA: begin
               shifter = {shifter[6:0], sda};
               enter(PH_RB);
            end
            PH_RB: begin
               if (bit_cnt >= 7) begin
                  bit_cnt = '0;
                  r.rd_data = shifter;
                  r.rd_valid = 1'b1;
                  bytes_left = bytes_left - 8'd1;
                  r.rd_last = (bytes_left == 0);
                  enter(r.rd_last ? PH_NA : PH_MA);
               end else begin
                  bit_cnt = bit_cnt + 4'd1;
                  enter(PH_RA);
               end
            end
            PH_MA: enter(PH_MB);
            PH_MB: enter(PH_MC);
            PH_MC: begin
               shifter = '0;
               bit_cnt = '0;
               enter(PH_RA);
            end
            PH_NA: enter(PH_NB);
            PH_NB: enter(PH_NC);
            PH_NC: enter(PH_PA);
            PH_PA: enter(PH_PB);
            PH_PB: enter(PH_PC);
            PH_PC: enter(PH_PD);
            default: begin
               r.done_res = 1'b1;
               r.nack_error = aborting;
               aborting = 1'b0;
               retries = '0;
               bit_cnt = '0;
               enter(PH_IDLE);
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: result beat %0d: %s is %0h, expected %0h", $time, beat_no, what,
               got, want);
      mismatch_total++;
   endtask

   task automatic compare_field(string what, int unsigned got, int unsigned want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_bus_model();
         bus_tick_results.delete();
      end else begin
         if (req_valid && req_ready)
            bus_tick_results.push_back(next_bus_tick(cmd_type'(req_cmd), req_reg_addr,
                                                     req_byte_count, req_write_data,
                                                     req_sda_in));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               CSR_DEVICE_ADDRESS:  dev_addr = csr_pwdata[6:0];
               CSR_PHASE_TICKS:     ticks_cfg = csr_pwdata[15:0];
               CSR_ACK_RETRY_LIMIT: retry_cfg = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (bus_tick_results.size() == 0) begin
               report_mismatch("unexpected beat, busy_res", rsp_busy_res, 0);
            end else begin
               want = bus_tick_results.pop_front();
               compare_field("scl_out", rsp_scl_out, want.scl_out);
               compare_field("sda_out", rsp_sda_out, want.sda_out);
               compare_field("rd_data", rsp_rd_data, want.rd_data);
               compare_field("rd_valid", rsp_rd_valid, want.rd_valid);
               compare_field("rd_last", rsp_rd_last, want.rd_last);
               compare_field("need_data", rsp_need_data, want.need_data);
               compare_field("done_res", rsp_done_res, want.done_res);
               compare_field("nack_error", rsp_nack_error, want.nack_error);
               compare_field("busy_res", rsp_busy_res, want.busy_res);
            end
            beat_no++;
         end
      end
      outstanding <= bus_tick_results.size();
      mismatches <= mismatch_total;
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access testbench
// Drives bus ticks and commands into the I2C master, paces the result side,
// and programs the registers between phases. Directed transfers cover the
// edge cases; random streams under changing pacing cover the rest. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cm_pkg::*;

   localparam int unsigned WatchdogLimit = 5000;
   localparam int unsigned RspHoldCycles = 400;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_cmd = CMD_TICK;
   logic [7:0]              req_reg_addr = '0;
   logic [7:0]              req_byte_count = '0;
   logic [7:0]              req_write_data = '0;
   logic                    req_sda_in = 1'b1;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_scl_out;
   logic                    rsp_sda_out;
   logic [7:0]              rsp_rd_data;
   logic                    rsp_rd_valid;
   logic                    rsp_rd_last;
   logic                    rsp_need_data;
   logic                    rsp_done_res;
   logic                    rsp_nack_error;
   logic                    rsp_busy_res;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned done_count = 0;
   int unsigned quiet_cycles = 0;
   logic        last_busy = 1'b0;

   i2c_master_register_access dut (.*);

   i2c_master_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : rsp_pacing
      int unsigned served;
      served = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_asked != served) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (RspHoldCycles - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         last_busy <= rsp_busy_res;
         if (rsp_done_res) done_count <= done_count + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_beat(cmd_type op, logic [7:0] pointer, logic [7:0] count,
                            logic [7:0] data, logic sda);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= op;
      req_reg_addr <= pointer;
      req_byte_count <= count;
      req_write_data <= data;
      req_sda_in <= sda;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CsrDataWidth-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_config(logic [31:0] dev, logic [31:0] ticks, logic [31:0] limit);
      csr_write(CSR_DEVICE_ADDRESS, dev);
      csr_write(CSR_PHASE_TICKS, ticks);
      csr_write(CSR_ACK_RETRY_LIMIT, limit);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Starts one transfer and clocks it until its STOP beat comes back. Two
   // start commands land early while the bus is busy and must be ignored.
   task automatic run_transfer(cmd_type op, logic [7:0] pointer, logic [7:0] count,
                               int unsigned high_pct);
      int unsigned done_mark;
      int unsigned n;
      done_mark = done_count;
      n = 0;
      send_beat(op, pointer, count, pick_byte(), 1'b0);
      while (done_count == done_mark) begin
         n++;
         if (n == 3)
            send_beat(CMD_WRITE, pick_byte(), 8'($urandom), pick_byte(), 1'b0);
         else if (n == 4)
            send_beat(CMD_READ, pick_byte(), 8'($urandom), pick_byte(), 1'b0);
         else
            send_beat(($urandom_range(99) < 30) ? CMD_SUPPLY : CMD_TICK, pick_byte(),
                      8'($urandom), pick_byte(), $urandom_range(99) < high_pct);
      end
   endtask

   task automatic random_stream(int unsigned beats);
      cmd_type     op;
      int unsigned r;
      logic [7:0]  count;
      repeat (beats) begin
         r = $urandom_range(99);
         op = (r < 55) ? CMD_TICK : (r < 80) ? CMD_SUPPLY : (r < 90) ? CMD_WRITE : CMD_READ;
         if (op == CMD_WRITE || op == CMD_READ)
            count = ($urandom_range(31) == 0) ? 8'($urandom) : 8'($urandom_range(3));
         else
            count = 8'($urandom);
         send_beat(op, pick_byte(), count, pick_byte(), $urandom_range(99) < 15);
      end
   endtask

   // Clocks the bus with acknowledges and data until it reports idle.
   task automatic settle_bus();
      do begin
         repeat (16)
            send_beat($urandom_range(1) ? CMD_SUPPLY : CMD_TICK, pick_byte(), 8'($urandom),
                      pick_byte(), 1'b0);
         wait_results();
      end while (last_busy);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 34;
      rsp_idle_pct = 80;

      csr_write(CSR_PHASE_TICKS, 32'd1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      run_transfer(CMD_WRITE, 8'h00, 8'd0, 0);
      wait_results();
      set_config(32'd127, 32'd1, 32'd255);
      run_transfer(CMD_WRITE, 8'hFF, 8'd1, 0);
      run_transfer(CMD_READ, 8'hA5, 8'd0, 0);
      run_transfer(CMD_READ, 8'h5A, 8'd2, 40);
      wait_results();
      set_config(32'd0, 32'd0, 32'd0);
      run_transfer(CMD_READ, 8'h00, 8'd255, 100);
      wait_results();
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);
      set_config(32'hFFFF_FFAA, 32'hABCD_0001, 32'h1234_5602);
      run_transfer(CMD_WRITE, 8'h3C, 8'd0, 30);
      wait_results();

      set_config(32'($urandom_range(127)), 32'd1, 32'd3);
      random_stream(15);
      hold_asked <= hold_asked + 1;
      random_stream(15);
      settle_bus();

      req_idle_pct = 80;
      rsp_idle_pct = 34;
      set_config(32'($urandom_range(127)), 32'd2, 32'd1);
      random_stream(15);
      wait_results();
      random_stream(15);
      settle_bus();

      set_config(32'($urandom_range(127)), 32'd65535, 32'd255);
      repeat (8)
         send_beat($urandom_range(1) ? CMD_SUPPLY : CMD_TICK, pick_byte(), 8'($urandom),
                   pick_byte(), 1'($urandom));
      settle_bus();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_config(32'($urandom_range(127)), 32'd1, 32'd8);
      random_stream(30);
      settle_bus();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
